FILE: rtl/minmax_peak_decimator_defines.svh
// Assertion macros shared by the min/max peak decimator RTL.
`ifndef MINMAX_PEAK_DECIMATOR_DEFINES_SVH
`define MINMAX_PEAK_DECIMATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MMPD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MMPD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mmpd_pkg.sv
// Shared widths, constants and beat types of the min/max peak decimator.
package mmpd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 17;
    localparam int RATIO_W     = 24;
    localparam int PHASE_W     = 25;
    localparam int S_TDATA_W   = 16;
    localparam int REC_BITS    = 2 * SAMPLE_W + COUNT_W;
    localparam int M_TDATA_W   = ((REC_BITS + 7) / 8) * 8;
    localparam int TDATA_PAD_W = M_TDATA_W - REC_BITS;

    // 1.0 in Q.8
    localparam logic [RATIO_W-1:0] ONE_Q8    = RATIO_W'(256);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       overflow;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] col_min;
        logic signed [SAMPLE_W-1:0] col_max;
        logic [COUNT_W-1:0]         count;
        logic                       overflow;
    } column_t;

endpackage

FILE: rtl/mmpd_in_stage.sv
// Input register stage: holds one accepted sample beat for the column update.
module mmpd_in_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mmpd_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] sample_value
    input  logic [0:0]                        s_tuser,   // [0] source_overflow
    input  logic                              take,
    output logic                              item_valid,
    output mmpd_pkg::sample_t                 item
);

    logic              valid_reg;
    logic              valid_next;
    mmpd_pkg::sample_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg && !take;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.value    <= s_tdata[mmpd_pkg::SAMPLE_W-1:0];
            item_reg.overflow <= s_tuser[0];
        end
    end

endmodule

FILE: rtl/mmpd_column.sv
// Column tracker: running min/max/count/flag, phase accumulator and ratio register.
`include "minmax_peak_decimator_defines.svh"

module mmpd_column (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mmpd_pkg::RATIO_W-1:0]    cfg_data,
    input  logic                            advance,
    input  mmpd_pkg::sample_t               item,
    output logic                            emit,
    output mmpd_pkg::column_t               record
);

    logic signed [mmpd_pkg::SAMPLE_W-1:0] min_reg, min_next, min_upd;
    logic signed [mmpd_pkg::SAMPLE_W-1:0] max_reg, max_next, max_upd;
    logic [mmpd_pkg::COUNT_W-1:0]         count_reg, count_next, count_upd;
    logic                                 ovf_reg, ovf_next, ovf_upd;
    logic [mmpd_pkg::PHASE_W-1:0]         phase_reg, phase_next, phase_sum, ratio_ext;
    logic [mmpd_pkg::RATIO_W-1:0]         ratio_reg, ratio_next;

    assign cfg_ready = 1'b1;

    // Clamp the ratio to 1.0 at write time so the compare sees the effective value.
    always_comb begin
        ratio_next = ratio_reg;
        if (cfg_valid) begin
            ratio_next = (cfg_data < mmpd_pkg::ONE_Q8) ? mmpd_pkg::ONE_Q8 : cfg_data;
        end
    end

    always_comb begin
        min_upd   = ($signed(item.value) < $signed(min_reg)) ? item.value : min_reg;
        max_upd   = ($signed(item.value) > $signed(max_reg)) ? item.value : max_reg;
        count_upd = (count_reg == mmpd_pkg::COUNT_MAX) ? count_reg
                                                       : count_reg + 1'b1;
        ovf_upd   = ovf_reg || item.overflow;
        phase_sum = phase_reg + mmpd_pkg::PHASE_W'(mmpd_pkg::ONE_Q8);
        ratio_ext = {1'b0, ratio_reg};
        emit      = phase_sum > ratio_ext;

        record.col_min  = min_upd;
        record.col_max  = max_upd;
        record.count    = count_upd;
        record.overflow = ovf_upd;

        min_next   = min_reg;
        max_next   = max_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        phase_next = phase_reg;
        if (advance) begin
            if (emit) begin
                // restart the column from this sample, carry the excess phase
                min_next   = item.value;
                max_next   = item.value;
                count_next = mmpd_pkg::COUNT_W'(1);
                ovf_next   = 1'b0;
                phase_next = phase_sum - ratio_ext;
            end else begin
                min_next   = min_upd;
                max_next   = max_upd;
                count_next = count_upd;
                ovf_next   = ovf_upd;
                phase_next = phase_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= '0;
            max_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            phase_reg <= '0;
            ratio_reg <= mmpd_pkg::ONE_Q8;
        end else begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            phase_reg <= phase_next;
            ratio_reg <= ratio_next;
        end
    end

    `MMPD_ASSERT_NOW(a_min_le_max, aclk, aresetn, 1'b1, min_reg <= max_reg, "min above max")
    `MMPD_ASSERT_NEXT(a_restart_count, aclk, aresetn, advance && emit,
                      count_reg == mmpd_pkg::COUNT_W'(1), "column did not restart at one")

endmodule

FILE: rtl/mmpd_out_reg.sv
// Output register: holds one column record beat until the sink takes it.
module mmpd_out_reg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  mmpd_pkg::column_t                 record,
    output logic                              free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mmpd_pkg::M_TDATA_W-1:0]    m_tdata,  // [15:0] column_min,
                                                        // [31:16] column_max,
                                                        // [48:32] column_count
    output logic [0:0]                        m_tuser   // [0] column_overflow
);

    logic              valid_reg;
    logic              valid_next;
    mmpd_pkg::column_t rec_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{mmpd_pkg::TDATA_PAD_W{1'b0}}, rec_reg.count,
                       rec_reg.col_max, rec_reg.col_min};
    assign m_tuser  = rec_reg.overflow;

    always_comb begin
        valid_next = valid_reg && !m_tready;
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= record;
        end
    end

endmodule

FILE: rtl/minmax_peak_decimator.sv
// Top level of the min/max peak decimator.
// Min/max peak-detect decimator for a display column. It takes one signed
// sample beat per clock and returns one column record (min, max, saturating
// count, sticky overflow) each time the Q17.8 phase, stepped by 1.0 per sample,
// passes the programmed samples-per-column ratio; the record includes the
// sample that closes it. The closing sample passes through one input register,
// then a combinational compare-and-add update of the column state into the
// output register, which presents the record on the master side. With
// the sink ready the block sustains one sample per clock; it stalls only when
// a record is due while the previous one has not been taken. The ratio write
// port (Q16.8, values below 1.0 act as 1.0) is always ready and is meant to be
// written while no sample is in flight. After reset min and max start at 0.
`include "minmax_peak_decimator_defines.svh"

module minmax_peak_decimator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mmpd_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] sample_value
    input  logic [0:0]                        s_tuser,   // [0] source_overflow
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mmpd_pkg::M_TDATA_W-1:0]    m_tdata,   // [15:0] column_min,
                                                         // [31:16] column_max,
                                                         // [48:32] column_count
    output logic [0:0]                        m_tuser,   // [0] column_overflow
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mmpd_pkg::RATIO_W-1:0]      cfg_data   // sample_ratio
);

    logic              item_valid;
    mmpd_pkg::sample_t item;
    logic              emit;
    mmpd_pkg::column_t record;
    logic              out_free;
    logic              take;

    // advance the held sample unless it closes a column and the output is full
    assign take = item_valid && (!emit || out_free);

    mmpd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mmpd_column u_column (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .advance   (take),
        .item      (item),
        .emit      (emit),
        .record    (record)
    );

    mmpd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && emit),
        .record   (record),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `MMPD_ASSERT_NEXT(a_emit_shows, aclk, aresetn, take && emit, m_tvalid, "record not shown")
    `MMPD_ASSERT_NOW(a_hold_blocks, aclk, aresetn, item_valid && !take, !s_tready,
                     "input ready while held sample stalled")

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the min/max peak decimator: directed table, random ratio phases.
module tb;

    typedef enum logic [0:0] {ROW_SAMPLE, ROW_RATIO} row_kind_t;
    typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_GIVEN} col_check_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [mmpd_pkg::RATIO_W-1:0]   arg;     // ratio, or sample in the low 16 bits
        logic                           ovf;
        col_check_t                     check;
        mmpd_pkg::column_t              col;
    } stim_row_t;

    localparam mmpd_pkg::column_t NO_COL = '0;

    localparam stim_row_t DIR_ROWS [24] = '{
        // first column after reset also spans 0
        '{ROW_SAMPLE, 24'h007FFF, 1'b0, EXP_NONE,  NO_COL},
        '{ROW_SAMPLE, 24'h008000, 1'b1, EXP_GIVEN, '{16'h8000, 16'h7FFF, 17'd2, 1'b1}},
        '{ROW_SAMPLE, 24'h000000, 1'b0, EXP_GIVEN, '{16'h8000, 16'h0000, 17'd2, 1'b0}},
        // ratios under 1.0 act as 1.0
        '{ROW_RATIO,  24'h000000, 1'b0, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h000005, 1'b0, EXP_GIVEN, '{16'h0000, 16'h0005, 17'd2, 1'b0}},
        '{ROW_RATIO,  24'h0000FF, 1'b0, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h00FFFF, 1'b1, EXP_GIVEN, '{16'hFFFF, 16'h0005, 17'd2, 1'b1}},
        '{ROW_RATIO,  24'h000200, 1'b0, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h000064, 1'b0, EXP_NONE,  NO_COL},
        '{ROW_SAMPLE, 24'h00FF9C, 1'b0, EXP_GIVEN, '{16'hFF9C, 16'h0064, 17'd3, 1'b0}},
        // fractional ratio; the second sample lands exactly on the ratio
        '{ROW_RATIO,  24'h000180, 1'b0, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h007FFE, 1'b1, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h008001, 1'b0, EXP_NONE,  NO_COL},
        '{ROW_SAMPLE, 24'h000001, 1'b0, EXP_PRED,  NO_COL},
        // ratio change mid-column, excess phase carries over
        '{ROW_RATIO,  24'hFFFFFF, 1'b0, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h001234, 1'b1, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h00EDCC, 1'b0, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h007FFF, 1'b0, EXP_PRED,  NO_COL},
        '{ROW_RATIO,  24'h000100, 1'b0, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h008000, 1'b0, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h000000, 1'b0, EXP_PRED,  NO_COL},
        '{ROW_RATIO,  24'h000101, 1'b0, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h005555, 1'b1, EXP_PRED,  NO_COL},
        '{ROW_SAMPLE, 24'h00AAAA, 1'b0, EXP_PRED,  NO_COL}
    };

    logic                             aclk;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [mmpd_pkg::S_TDATA_W-1:0]   s_tdata = '0;   // [15:0] sample_value
    logic [0:0]                       s_tuser = '0;   // [0] source_overflow
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [mmpd_pkg::M_TDATA_W-1:0]   m_tdata;        // [15:0] min, [31:16] max, [48:32] count
    logic [0:0]                       m_tuser;        // [0] column_overflow
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [mmpd_pkg::RATIO_W-1:0]     cfg_data = '0;

    minmax_peak_decimator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // column predictor state
    logic signed [mmpd_pkg::SAMPLE_W-1:0] col_lo = '0;
    logic signed [mmpd_pkg::SAMPLE_W-1:0] col_hi = '0;
    logic [mmpd_pkg::COUNT_W-1:0]         col_count = '0;
    logic                                 col_ovf = 1'b0;
    logic [mmpd_pkg::PHASE_W-1:0]         phase_q8 = '0;
    logic [mmpd_pkg::RATIO_W-1:0]         ratio_reg = mmpd_pkg::ONE_Q8;

    mmpd_pkg::column_t pending_columns [$];
    int                mismatches = 0;
    bit                gaps_on = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 100)
            $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Fold one sample into the open column; close it once the phase passes the ratio.
    task automatic fold_sample(input logic [mmpd_pkg::SAMPLE_W-1:0] raw, input logic ovf,
                               output bit made, output mmpd_pkg::column_t rec);
        logic signed [mmpd_pkg::SAMPLE_W-1:0] v;
        logic [mmpd_pkg::RATIO_W-1:0]         eff;
        v = raw;
        eff = (ratio_reg < mmpd_pkg::ONE_Q8) ? mmpd_pkg::ONE_Q8 : ratio_reg;
        made = 1'b0;
        rec = '0;
        if (ovf)
            col_ovf = 1'b1;
        if (col_count != mmpd_pkg::COUNT_MAX)
            col_count = col_count + 1'b1;
        if (v < col_lo)
            col_lo = v;
        if (v > col_hi)
            col_hi = v;
        phase_q8 = phase_q8 + mmpd_pkg::PHASE_W'(mmpd_pkg::ONE_Q8);
        if (phase_q8 > mmpd_pkg::PHASE_W'(eff)) begin
            made = 1'b1;
            rec.col_min = col_lo;
            rec.col_max = col_hi;
            rec.count = col_count;
            rec.overflow = col_ovf;
            phase_q8 = phase_q8 - mmpd_pkg::PHASE_W'(eff);
            col_lo = v;
            col_hi = v;
            col_count = mmpd_pkg::COUNT_W'(1);
            col_ovf = 1'b0;
        end
    endtask

    function automatic logic [mmpd_pkg::SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [mmpd_pkg::SAMPLE_W-1:0] v, input logic ovf,
                               input col_check_t check, input mmpd_pkg::column_t given);
        mmpd_pkg::column_t rec;
        bit                made;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tuser <= ovf;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fold_sample(v, ovf, made, rec);
        if (check == EXP_GIVEN)
            pending_columns.push_back(given);
        else if (check == EXP_PRED && made)
            pending_columns.push_back(rec);
    endtask

    // Hold the input until every column is out, then let the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_columns.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_ratio(input logic [mmpd_pkg::RATIO_W-1:0] r);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= r;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        ratio_reg = r;
    endtask

    // sink side: random stall bursts while gaps are on
    initial begin
        @(posedge aclk);
        forever begin
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : check_columns
        mmpd_pkg::column_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_columns.size() == 0) begin
                report_mismatch("unexpected column", m_tdata[31:0], 0);
            end else begin
                want = pending_columns.pop_front();
                if (m_tdata[15:0] != want.col_min)
                    report_mismatch("column_min", m_tdata[15:0], want.col_min);
                if (m_tdata[31:16] != want.col_max)
                    report_mismatch("column_max", m_tdata[31:16], want.col_max);
                if (m_tdata[48:32] != want.count)
                    report_mismatch("column_count", m_tdata[48:32], want.count);
                if (m_tuser[0] != want.overflow)
                    report_mismatch("column_overflow", m_tuser[0], want.overflow);
            end
        end
    end

    initial begin
        int unsigned                  rand_items;
        int unsigned                  tail;
        int                           span;
        int                           spins;
        logic [mmpd_pkg::RATIO_W-1:0] r;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].kind == ROW_RATIO)
                write_ratio(DIR_ROWS[i].arg);
            else
                send_sample(DIR_ROWS[i].arg[mmpd_pkg::SAMPLE_W-1:0], DIR_ROWS[i].ovf,
                            DIR_ROWS[i].check, DIR_ROWS[i].col);
        end

        // random phases, each with its own ratio
        rand_items = 0;
        while (rand_items < 820) begin
            case ($urandom_range(0, 7))
                0: r = mmpd_pkg::RATIO_W'($urandom_range(0, 255));
                1: r = mmpd_pkg::ONE_Q8;
                2: r = mmpd_pkg::RATIO_W'($urandom_range(257, 1023));
                3: r = mmpd_pkg::RATIO_W'($urandom_range(1024, 8191));
                4: r = 24'hFFFFFF;
                5: r = 24'($urandom);
                default: r = mmpd_pkg::RATIO_W'($urandom_range(256, 600));
            endcase
            write_ratio(r);
            gaps_on = ($urandom_range(0, 3) != 0);
            span = $urandom_range(20, 80);
            repeat (span) begin
                if ($urandom_range(0, 99) == 0)
                    settle();
                send_sample(pick_value(), $urandom_range(0, 7) == 0, EXP_PRED, NO_COL);
                rand_items++;
            end
        end

        // no gaps from here on: a short back-to-back run at a small ratio
        gaps_on = 1'b0;
        write_ratio(mmpd_pkg::RATIO_W'($urandom_range(256, 1023)));
        for (tail = 0; tail < 48; tail++)
            send_sample(pick_value(), $urandom_range(0, 7) == 0, EXP_PRED, NO_COL);
        s_tvalid <= 1'b0;

        for (spins = 0; spins < 4000 && pending_columns.size() != 0; spins++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (pending_columns.size() != 0)
            report_mismatch("missing column", pending_columns.size(), 0);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
